@@ design/sine_cosine_polynomial_unit_defines.svh @@
// Assertion helpers shared by the RTL. The clock is clk and the reset is rst_n
// in every module that uses them.
`ifndef SINE_COSINE_POLYNOMIAL_UNIT_DEFINES_SVH
`define SINE_COSINE_POLYNOMIAL_UNIT_DEFINES_SVH

// Property checked at every clock edge outside reset.
`define SCP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Implication checked in the same cycle.
`define SCP_ASSERT_IMPL(lbl, ante, cons, msg) \
  `SCP_ASSERT(lbl, (ante) |-> (cons), msg)

`endif

@@ design/scp_pkg.sv @@
package scp_pkg;

  // Field widths
  localparam int ANGLE_W = 16;
  localparam int OUT_W   = 16;
  localparam int MAG_W   = 15;

  // Internal fixed point: Q3.29
  localparam int FRAC_BITS   = 29;
  localparam int ANGLE_SHIFT = 16;
  localparam int XW          = 32;  // angle after shift
  localparam int RW          = 30;  // remainder after quadrant removal
  localparam int TW          = 29;  // folded argument and its powers
  localparam int VW          = 30;  // series sums
  localparam int MW          = 30;  // reciprocal multipliers
  localparam int Q14_FRAC    = 14;
  localparam int OUT_SHIFT   = FRAC_BITS - Q14_FRAC;

  localparam logic [XW-1:0] TWO_PI_Q     = 32'd3373259426;
  localparam logic [XW-1:0] HALF_PI_Q    = 32'd843314857;
  localparam logic [XW-1:0] PI_Q         = XW'(64'd2 * 64'(HALF_PI_Q));
  localparam logic [XW-1:0] THREE_HALF_Q = XW'(64'd3 * 64'(HALF_PI_Q));
  localparam logic [XW-1:0] QUARTER_PI_Q = 32'd421657428;
  localparam logic [VW-1:0] ONE_Q        = VW'(64'd1 << FRAC_BITS);
  localparam logic [VW:0]   ROUND_Q14    = (VW+1)'(64'd1 << Q14_FRAC);
  localparam logic [MAG_W-1:0] Q14_ONE   = MAG_W'(64'd1 << Q14_FRAC);

  localparam logic signed [OUT_W-1:0] OUT_MAX = OUT_W'(64'd1 << Q14_FRAC);
  localparam logic signed [OUT_W-1:0] OUT_MIN = -OUT_MAX;

  // Exact floor division of a TW-bit value by d: (v * ceil(2^k / d)) >> k,
  // with k = TW + ceil(log2(d)).
  localparam int DIV6_K   = FRAC_BITS + 3;
  localparam int DIV24_K  = FRAC_BITS + 5;
  localparam int DIV120_K = FRAC_BITS + 7;
  localparam int DIV720_K = FRAC_BITS + 10;
  localparam logic [MW-1:0] DIV6_M   = MW'(((64'd1 << DIV6_K) + 64'd5) / 64'd6);
  localparam logic [MW-1:0] DIV24_M  = MW'(((64'd1 << DIV24_K) + 64'd23) / 64'd24);
  localparam logic [MW-1:0] DIV120_M = MW'(((64'd1 << DIV120_K) + 64'd119) / 64'd120);
  localparam logic [MW-1:0] DIV720_M = MW'(((64'd1 << DIV720_K) + 64'd719) / 64'd720);

  typedef enum logic [1:0] {
    QUAD_0 = 2'd0,
    QUAD_1 = 2'd1,
    QUAD_2 = 2'd2,
    QUAD_3 = 2'd3
  } quad_t;

  // Travels alongside the series with each request
  typedef struct packed {
    quad_t quad;
    logic  swap;
  } scp_side_t;

endpackage

@@ design/scp_in_if.sv @@
interface scp_in_if import scp_pkg::*;;
  logic               valid;
  logic               ready;
  logic [ANGLE_W-1:0] angle;

  modport source (output valid, output angle, input ready);
  modport sink   (input valid, input angle, output ready);
endinterface

@@ design/scp_out_if.sv @@
interface scp_out_if import scp_pkg::*;;
  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] sine;
  logic signed [OUT_W-1:0] cosine;

  modport source (output valid, output sine, output cosine, input ready);
  modport sink   (input valid, input sine, input cosine, output ready);
endinterface

@@ design/scp_series.sv @@
module scp_series import scp_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [TW-1:0]   in_t,
  input  scp_side_t       in_side,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [VW-1:0]   out_sv,
  output logic [VW-1:0]   out_cv,
  output scp_side_t       out_side
);

  localparam int NST = 7;

  function automatic logic [TW-1:0] fx_mul(input logic [TW-1:0] a, input logic [TW-1:0] b);
    logic [2*TW-1:0] prod;
    prod = a * b;
    return prod[FRAC_BITS +: TW];
  endfunction

  function automatic logic [TW-1:0] div_rcp(input logic [TW-1:0] v, input logic [MW-1:0] m,
                                            input int k);
    logic [TW+MW-1:0] prod;
    logic [TW+MW-1:0] sh;
    prod = v * m;
    sh   = prod >> k;
    return sh[TW-1:0];
  endfunction

  logic [NST-1:0] v_r, v_nxt, en;
  scp_side_t      side_r [NST];

  logic [TW-1:0] t_a_r, p2_a_r;
  logic [TW-1:0] t_b_r, p3_b_r, h2_b_r;
  logic [TW-1:0] t_c_r, p4_c_r, d3_c_r, h2_c_r;
  logic [TW-1:0] t_d_r, p5_d_r, d4_d_r, d3_d_r, h2_d_r;
  logic [TW-1:0] t_e_r, p6_e_r, d5_e_r, d3_e_r;
  logic [VW-1:0] cp_e_r;
  logic [TW-1:0] d6_f_r;
  logic [VW-1:0] sv_f_r, cp_f_r;
  logic [VW-1:0] sv_g_r, cv_g_r;

  // A stage moves when it is empty or the next one moves
  always_comb begin
    en[NST-1] = !v_r[NST-1] || out_ready;
    for (int k = NST - 2; k >= 0; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
    v_nxt[0] = en[0] ? in_valid : v_r[0];
    for (int k = 1; k < NST; k++) begin
      v_nxt[k] = en[k] ? v_r[k-1] : v_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) side_r[0] <= in_side;
    for (int k = 1; k < NST; k++) begin
      if (en[k]) side_r[k] <= side_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      t_a_r  <= in_t;
      p2_a_r <= fx_mul(in_t, in_t);
    end
    if (en[1]) begin
      t_b_r  <= t_a_r;
      p3_b_r <= fx_mul(p2_a_r, t_a_r);
      h2_b_r <= p2_a_r >> 1;
    end
    if (en[2]) begin
      t_c_r  <= t_b_r;
      p4_c_r <= fx_mul(p3_b_r, t_b_r);
      d3_c_r <= div_rcp(p3_b_r, DIV6_M, DIV6_K);
      h2_c_r <= h2_b_r;
    end
    if (en[3]) begin
      t_d_r  <= t_c_r;
      p5_d_r <= fx_mul(p4_c_r, t_c_r);
      d4_d_r <= div_rcp(p4_c_r, DIV24_M, DIV24_K);
      d3_d_r <= d3_c_r;
      h2_d_r <= h2_c_r;
    end
    if (en[4]) begin
      t_e_r  <= t_d_r;
      p6_e_r <= fx_mul(p5_d_r, t_d_r);
      d5_e_r <= div_rcp(p5_d_r, DIV120_M, DIV120_K);
      d3_e_r <= d3_d_r;
      cp_e_r <= ONE_Q + VW'(d4_d_r) - VW'(h2_d_r);
    end
    if (en[5]) begin
      d6_f_r <= div_rcp(p6_e_r, DIV720_M, DIV720_K);
      // partial sums never go negative for arguments up to pi/4
      sv_f_r <= VW'(t_e_r) + VW'(d5_e_r) - VW'(d3_e_r);
      cp_f_r <= cp_e_r;
    end
    if (en[6]) begin
      sv_g_r <= sv_f_r;
      cv_g_r <= cp_f_r - VW'(d6_f_r);
    end
  end

  assign in_ready  = en[0];
  assign out_valid = v_r[NST-1];
  assign out_sv    = sv_g_r;
  assign out_cv    = cv_g_r;
  assign out_side  = side_r[NST-1];

endmodule

@@ design/sine_cosine_polynomial_unit.sv @@
// Sine and cosine of an unsigned Q3.13 angle in radians, as signed Q1.14 values
// saturated to plus or minus one. The angle is reduced modulo two pi, folded to
// at most pi/4 by quadrant and octant, and run through short Taylor series
// (sine to x^5, cosine to x^6). The unit is a 12-stage pipeline, and a new
// request is taken every cycle as long as results are drained. The depth
// comes from the seven series stages (five registered 29x29 fixed-point
// multiplications that build x^2 through x^6, then the last division and the
// final sums), plus three stages of range reduction in front and two of
// rounding and sign handling behind.
// No reset sequence is needed beyond rst_n.
`include "sine_cosine_polynomial_unit_defines.svh"

module sine_cosine_polynomial_unit import scp_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  scp_in_if.sink     in_chan,
  scp_out_if.source  out_chan
);

  function automatic logic [MAG_W-1:0] to_q14(input logic [VW-1:0] v);
    logic [VW:0]           sum;
    logic [VW-OUT_SHIFT:0] rnd;
    sum = {1'b0, v} + ROUND_Q14;
    rnd = sum[VW:OUT_SHIFT];
    if (rnd > (VW-OUT_SHIFT+1)'(Q14_ONE)) begin
      return Q14_ONE;
    end
    return rnd[MAG_W-1:0];
  endfunction

  function automatic logic [OUT_W-1:0] encode(input logic [MAG_W-1:0] mag, input logic neg);
    logic [OUT_W-1:0] ext;
    ext = {1'b0, mag};
    return neg ? (OUT_W'(0) - ext) : ext;
  endfunction

  // front stages 1..3, back stages 4..5
  logic v1_r, v2_r, v3_r, v4_r, v5_r;
  logic v1_nxt, v2_nxt, v3_nxt, v4_nxt, v5_nxt;
  logic en1, en2, en3, en4, en5;

  logic [XW-1:0]    x1_r;
  quad_t            q2_r;
  logic [RW-1:0]    r2_r;
  logic [TW-1:0]    t3_r;
  scp_side_t        side3_r, side4_r;
  logic [MAG_W-1:0] sm4_r, cm4_r;
  logic [OUT_W-1:0] sine_r, cosine_r;

  logic             ser_in_ready, ser_out_valid;
  logic [VW-1:0]    ser_sv, ser_cv;
  scp_side_t        ser_side;

  logic [XW-1:0]    x_in;
  quad_t            q_nxt;
  logic [XW-1:0]    q_off;
  logic             swap_nxt;
  logic [XW-1:0]    fold;
  logic [MAG_W-1:0] s_sw, c_sw, smag, cmag;
  logic             sneg, cneg;
  logic             out_in_range;

  scp_series u_series (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (v3_r),
    .in_ready  (ser_in_ready),
    .in_t      (t3_r),
    .in_side   (side3_r),
    .out_valid (ser_out_valid),
    .out_ready (en4),
    .out_sv    (ser_sv),
    .out_cv    (ser_cv),
    .out_side  (ser_side)
  );

  // Handshake chain
  always_comb begin
    en5 = !v5_r || out_chan.ready;
    en4 = !v4_r || en5;
    en3 = !v3_r || ser_in_ready;
    en2 = !v2_r || en3;
    en1 = !v1_r || en2;
    v1_nxt = en1 ? in_chan.valid : v1_r;
    v2_nxt = en2 ? v1_r : v2_r;
    v3_nxt = en3 ? v2_r : v3_r;
    v4_nxt = en4 ? ser_out_valid : v4_r;
    v5_nxt = en5 ? v4_r : v5_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      v1_r <= v1_nxt;
      v2_r <= v2_nxt;
      v3_r <= v3_nxt;
      v4_r <= v4_nxt;
      v5_r <= v5_nxt;
    end
  end

  // Range reduction and fold
  always_comb begin
    x_in = {in_chan.angle, ANGLE_SHIFT'(0)};
    priority if (x1_r >= THREE_HALF_Q) begin
      q_nxt = QUAD_3;
      q_off = THREE_HALF_Q;
    end else if (x1_r >= PI_Q) begin
      q_nxt = QUAD_2;
      q_off = PI_Q;
    end else if (x1_r >= HALF_PI_Q) begin
      q_nxt = QUAD_1;
      q_off = HALF_PI_Q;
    end else begin
      q_nxt = QUAD_0;
      q_off = '0;
    end
    // exactly pi/4 stays on the direct series
    swap_nxt = XW'(r2_r) > QUARTER_PI_Q;
    fold     = swap_nxt ? (HALF_PI_Q - XW'(r2_r)) : XW'(r2_r);
  end

  always_ff @(posedge clk) begin
    if (en1) x1_r <= (x_in >= TWO_PI_Q) ? (x_in - TWO_PI_Q) : x_in;
    if (en2) begin
      q2_r <= q_nxt;
      r2_r <= RW'(x1_r - q_off);
    end
    if (en3) begin
      t3_r    <= fold[TW-1:0];
      side3_r <= '{quad: q2_r, swap: swap_nxt};
    end
  end

  // Octant swap, quadrant signs
  always_comb begin
    s_sw = side4_r.swap ? cm4_r : sm4_r;
    c_sw = side4_r.swap ? sm4_r : cm4_r;
    unique case (side4_r.quad)
      QUAD_0: begin smag = s_sw; sneg = 1'b0; cmag = c_sw; cneg = 1'b0; end
      QUAD_1: begin smag = c_sw; sneg = 1'b0; cmag = s_sw; cneg = 1'b1; end
      QUAD_2: begin smag = s_sw; sneg = 1'b1; cmag = c_sw; cneg = 1'b1; end
      QUAD_3: begin smag = c_sw; sneg = 1'b1; cmag = s_sw; cneg = 1'b0; end
      default: begin smag = s_sw; sneg = 1'b0; cmag = c_sw; cneg = 1'b0; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en4) begin
      sm4_r   <= to_q14(ser_sv);
      cm4_r   <= to_q14(ser_cv);
      side4_r <= ser_side;
    end
    if (en5) begin
      sine_r   <= encode(smag, sneg);
      cosine_r <= encode(cmag, cneg);
    end
  end

  assign in_chan.ready   = en1;
  assign out_chan.valid  = v5_r;
  assign out_chan.sine   = sine_r;
  assign out_chan.cosine = cosine_r;

  assign out_in_range = $signed(sine_r) >= OUT_MIN && $signed(sine_r) <= OUT_MAX &&
                        $signed(cosine_r) >= OUT_MIN && $signed(cosine_r) <= OUT_MAX;

  `SCP_ASSERT_IMPL(a_reduced, v1_r, x1_r < TWO_PI_Q, "angle not reduced below two pi")
  `SCP_ASSERT_IMPL(a_quad_rem, v2_r, XW'(r2_r) < HALF_PI_Q, "quadrant remainder too large")
  `SCP_ASSERT_IMPL(a_fold, v3_r, XW'(t3_r) <= QUARTER_PI_Q, "folded argument above pi/4")
  `SCP_ASSERT_IMPL(a_drained, !v5_r, in_chan.ready, "input stalled with empty output stage")
  `SCP_ASSERT_IMPL(a_range, v5_r, out_in_range, "result out of range")

endmodule

@@ dv/tb_top.sv @@
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import scp_pkg::*;

  // Q3.29 constants of the angle reduction, kept apart from the RTL's copies
  localparam bit [63:0] TWO_PI_FX     = 64'd3373259426;
  localparam bit [63:0] HALF_PI_FX    = 64'd843314857;
  localparam bit [63:0] QUARTER_PI_FX = 64'd421657428;
  localparam int        FX_FRAC       = 29;
  localparam bit [63:0] FX_ONE        = 64'd1 << FX_FRAC;
  localparam bit [63:0] UNIT_Q14      = 64'd16384;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 40;
  localparam int MAX_REPORTS  = 10;

  typedef struct {
    logic signed [OUT_W-1:0] sine;
    logic signed [OUT_W-1:0] cosine;
  } sincos_t;

  logic clk;
  logic rst_n;

  scp_in_if  in_chan();
  scp_out_if out_chan();

  sine_cosine_polynomial_unit dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  sincos_t pending_pairs[$];
  int      send_idle_pct;
  int      recv_stall_pct;
  int      hold_request;
  int      cycle_count;
  int      error_count;
  int      report_count;
  int      angles_sent;
  int      results_seen;
  int      input_stall_cycles;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------
  function automatic bit [63:0] fx_mul(input bit [63:0] a, input bit [63:0] b);
    return (a * b) >> FX_FRAC;
  endfunction

  function automatic bit [63:0] round_q14(input bit [63:0] v);
    bit [63:0] r;
    r = (v + (64'd1 << 14)) >> 15;
    return (r > UNIT_Q14) ? UNIT_Q14 : r;
  endfunction

  // Negation after saturation; a negated zero stays zero
  function automatic logic signed [OUT_W-1:0] signed_q14(input bit [63:0] mag, input bit neg);
    bit [63:0] v;
    v = neg ? ((64'h10000 - mag) & 64'hFFFF) : (mag & 64'hFFFF);
    return v[OUT_W-1:0];
  endfunction

  function automatic sincos_t sincos_predict(input logic [ANGLE_W-1:0] angle);
    bit [63:0] x, r, t, t2, t3, t4, t5, t6, sv, cv, s, c, tmp;
    bit        fold;
    quad_t     quad;
    sincos_t   res;
    x = 64'(angle) << 16;
    if (x >= TWO_PI_FX) x -= TWO_PI_FX;
    if (x >= 3 * HALF_PI_FX)      quad = QUAD_3;
    else if (x >= 2 * HALF_PI_FX) quad = QUAD_2;
    else if (x >= HALF_PI_FX)     quad = QUAD_1;
    else                          quad = QUAD_0;
    r = x - 64'(quad) * HALF_PI_FX;
    // octant fold: r exactly at pi/4 keeps the direct series
    fold = (r > QUARTER_PI_FX);
    t  = fold ? (HALF_PI_FX - r) : r;
    t2 = fx_mul(t, t);
    t3 = fx_mul(t2, t);
    t4 = fx_mul(t3, t);
    t5 = fx_mul(t4, t);
    t6 = fx_mul(t5, t);
    sv = t + t5 / 120 - t3 / 6;
    cv = FX_ONE + t4 / 24 - t2 / 2 - t6 / 720;
    s = round_q14(sv);
    c = round_q14(cv);
    if (fold) begin
      tmp = s;
      s = c;
      c = tmp;
    end
    case (quad)
      QUAD_0: begin
        res.sine   = signed_q14(s, 1'b0);
        res.cosine = signed_q14(c, 1'b0);
      end
      QUAD_1: begin
        res.sine   = signed_q14(c, 1'b0);
        res.cosine = signed_q14(s, 1'b1);
      end
      QUAD_2: begin
        res.sine   = signed_q14(s, 1'b1);
        res.cosine = signed_q14(c, 1'b1);
      end
      default: begin
        res.sine   = signed_q14(c, 1'b1);
        res.cosine = signed_q14(s, 1'b0);
      end
    endcase
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Clock, cycle count, watchdog
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("timeout after %0d cycles, %0d results outstanding",
             cycle_count, pending_pairs.size());
    $display("sine_cosine_polynomial_unit: mismatch");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Input monitor: predict on every accepted request
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && in_chan.valid) begin
      if (in_chan.ready) begin
        pending_pairs.push_back(sincos_predict(in_chan.angle));
        angles_sent++;
      end else begin
        input_stall_cycles++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result checker
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    sincos_t want;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      results_seen++;
      if (pending_pairs.size() == 0) begin
        error_count++;
        if (report_count < MAX_REPORTS) begin
          report_count++;
          $display("unexpected result sine=%0d cosine=%0d at cycle %0d",
                   out_chan.sine, out_chan.cosine, cycle_count);
        end
      end else begin
        want = pending_pairs.pop_front();
        if (out_chan.sine !== want.sine || out_chan.cosine !== want.cosine) begin
          error_count++;
          if (report_count < MAX_REPORTS) begin
            report_count++;
            $display("result %0d: sine exp %0d got %0d, cosine exp %0d got %0d",
                     results_seen, want.sine, out_chan.sine, want.cosine, out_chan.cosine);
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: random stalls plus a long hold-off on request
  // ---------------------------------------------------------------------------
  initial begin
    int hold_left;
    hold_left = 0;
    out_chan.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request > 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_chan.ready <= 1'b0;
      end else begin
        out_chan.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  // Leaves valid high after acceptance; the next call either keeps it or drops it.
  task automatic send_angle(input logic [ANGLE_W-1:0] angle);
    int gap;
    gap = 0;
    while (gap < 20 && $urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_chan.valid <= 1'b1;
    in_chan.angle <= angle;
    do @(posedge clk); while (!in_chan.ready);
  endtask

  function automatic logic [ANGLE_W-1:0] octant_edge(input int k);
    return ANGLE_W'((64'(k) * QUARTER_PI_FX) >> 16);
  endfunction

  task automatic test_directed();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_angle(16'h0000);
    send_angle(16'h0001);
    send_angle(16'hFFFF);
    send_angle(16'h5555);
    send_angle(16'hAAAA);
    // both sides of every octant edge: pi/4 folds, quadrants, the 2 pi wrap
    for (int k = 1; k <= 10; k++) begin
      send_angle(octant_edge(k));
      send_angle(octant_edge(k) + 1'b1);
    end
  endtask

  task automatic test_random(input int idle_pct, input int stall_pct, input int count);
    logic [ANGLE_W-1:0] angle;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(99) < 70)
        angle = ANGLE_W'($urandom);
      else
        angle = ANGLE_W'(int'(octant_edge($urandom_range(10, 1))) +
                         int'($urandom_range(6)) - 3);
      send_angle(angle);
    end
  endtask

  // Output held off long enough for the pipeline to fill and push back on input
  task automatic test_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_request   = 150;
    for (int i = 0; i < 60; i++) send_angle(ANGLE_W'($urandom));
  endtask

  task automatic drain_results();
    in_chan.valid <= 1'b0;
    while (pending_pairs.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_pairs.size() != 0) begin
      error_count += pending_pairs.size();
      $display("%0d results never arrived", pending_pairs.size());
    end
  endtask

  initial begin
    rst_n          = 1'b0;
    in_chan.valid  = 1'b0;
    in_chan.angle  = '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_request   = 0;
    cycle_count    = 0;
    error_count    = 0;
    report_count   = 0;
    angles_sent    = 0;
    results_seen   = 0;
    input_stall_cycles = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_random(0, 0, 310);
    test_random(60, 0, 310);
    test_random(0, 60, 310);
    test_random(30, 30, 310);
    test_backpressure();
    test_random(0, 0, 50);
    drain_results();

    $display("%0d angles in, %0d results out, idle mixes none/input/output/both",
             angles_sent, results_seen);
    $display("output stalls, long hold-off included, held back the input for %0d cycles",
             input_stall_cycles);
    if (error_count == 0)
      $display("sine_cosine_polynomial_unit: match");
    else
      $display("sine_cosine_polynomial_unit: mismatch");
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+design
design/scp_pkg.sv
design/scp_in_if.sv
design/scp_out_if.sv
design/scp_series.sv
design/sine_cosine_polynomial_unit.sv
dv/tb_top.sv
